>>> hw/rtl/alu_flg_pkg.sv
// Shared types for the 8-bit ALU with flags: operation codes and the flag group.
`timescale 1ns / 1ps
`default_nettype none

package alu_flg_pkg;

	// Operation codes as carried on the mode port
	typedef enum logic [4:0] {
		MODE_ADD    = 5'd0,
		MODE_ADC    = 5'd1,
		MODE_SUB    = 5'd2,
		MODE_SBC    = 5'd3,
		MODE_AND    = 5'd4,
		MODE_XOR    = 5'd5,
		MODE_OR     = 5'd6,
		MODE_CP     = 5'd7,
		MODE_INC    = 5'd8,
		MODE_DEC    = 5'd9,
		MODE_RLCA   = 5'd10,
		MODE_RRCA   = 5'd11,
		MODE_RLA    = 5'd12,
		MODE_RRA    = 5'd13,
		MODE_RLC    = 5'd14,
		MODE_RRC    = 5'd15,
		MODE_RL     = 5'd16,
		MODE_RR     = 5'd17,
		MODE_SLA    = 5'd18,
		MODE_SRA    = 5'd19,
		MODE_SWAP   = 5'd20,
		MODE_SRL    = 5'd21,
		MODE_BIT    = 5'd22,
		MODE_RES    = 5'd23,
		MODE_SET    = 5'd24,
		MODE_CPL    = 5'd25,
		MODE_CCF    = 5'd26,
		MODE_SCF    = 5'd27,
		MODE_ADD16  = 5'd28,
		MODE_ADDSP  = 5'd29,
		MODE_INC16  = 5'd30,
		MODE_DEC16  = 5'd31
	} mode_t;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/cpu_alu_with_flags.sv
// Top level of the 8-bit ALU with flags: input register, ALU datapath, result register.
// An accepted beat passes through the input register and then the result register, which raises done with its result.
// Throughput: one beat per cycle; busy stays low, so start may be held high every cycle.
// The result register is the only output stage and the receiver cannot stall it.
// Reset (arst_n low, asynchronous): clears the valid bits of both stages, so done drops at once.
`timescale 1ns / 1ps
`default_nettype none

module cpu_alu_with_flags
	import alu_flg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [4:0]  mode,
	input  logic [15:0] operand_a,
	input  logic [15:0] operand_b,
	input  logic [2:0]  bit_index,
	input  logic        in_zero,
	input  logic        in_sub,
	input  logic        in_half,
	input  logic        in_carry,
	output logic        done,
	output logic [15:0] result,
	output logic        out_zero,
	output logic        out_sub,
	output logic        out_half,
	output logic        out_carry
);

	// Stage 1: captured operation beat
	logic        valid_s1;
	mode_t       mode_s1;
	logic [15:0] opa_s1;
	logic [15:0] opb_s1;
	logic [2:0]  bidx_s1;
	flags_t      flags_s1;

	// Stage 2: registered result beat
	logic        valid_s2;
	logic [15:0] result_s2;
	flags_t      flags_s2;

	logic [15:0] core_result;
	flags_t      core_flags;
	logic        accept;

	// No state carries between beats, so the block never pushes back
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Control: advance the valid bit through both stages every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// Payload: capture only on an accepted beat, hold otherwise
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode_t'(mode);
			opa_s1   <= operand_a;
			opb_s1   <= operand_b;
			bidx_s1  <= bit_index;
			flags_s1 <= '{z: in_zero, n: in_sub, h: in_half, c: in_carry};
		end
	end

	alu_flg_core u_core (
		.mode      (mode_s1),
		.opa       (opa_s1),
		.opb       (opb_s1),
		.bit_index (bidx_s1),
		.flags_in  (flags_s1),
		.result    (core_result),
		.flags_out (core_flags)
	);

	// Result register: load when stage 1 holds a live beat
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= core_result;
			flags_s2  <= core_flags;
		end
	end

	assign done      = valid_s2;
	assign result    = result_s2;
	assign out_zero  = flags_s2.z;
	assign out_sub   = flags_s2.n;
	assign out_half  = flags_s2.h;
	assign out_carry = flags_s2.c;

`ifndef SYNTH
	// Every done beat traces back to an accepted beat that passed through stage 1 and stage 2
	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("done without a matching accepted beat");

	// 8-bit operations leave the upper result byte clear
	a_byte_ops_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (mode_s1 != MODE_ADD16) && (mode_s1 != MODE_ADDSP)
			&& (mode_s1 != MODE_INC16) && (mode_s1 != MODE_DEC16))
		|=> (result[15:8] == 8'h00))
		else $error("8-bit operation drove the upper result byte");

	// Word inc/dec and bit res/set pass all flags through
	a_flags_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ((mode_s1 == MODE_INC16) || (mode_s1 == MODE_DEC16)
			|| (mode_s1 == MODE_RES) || (mode_s1 == MODE_SET)))
		|=> ({out_zero, out_sub, out_half, out_carry} == $past(flags_s1)))
		else $error("flags changed by a flag-preserving operation");

	// Compare, bit test, ccf and scf return the operand unchanged
	a_operand_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ((mode_s1 == MODE_CP) || (mode_s1 == MODE_BIT)
			|| (mode_s1 == MODE_CCF) || (mode_s1 == MODE_SCF)))
		|=> (result == {8'h00, $past(opa_s1[7:0])}))
		else $error("operand not returned unchanged");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/alu_flg_core.sv
// Combinational ALU datapath: 8-bit add/sub, logic, shifts, bit ops and 16-bit adds.
`timescale 1ns / 1ps
`default_nettype none

module alu_flg_core
	import alu_flg_pkg::*;
(
	input  mode_t        mode,
	input  logic [15:0]  opa,
	input  logic [15:0]  opb,
	input  logic [2:0]   bit_index,
	input  flags_t       flags_in,
	output logic [15:0]  result,
	output flags_t       flags_out
);

	logic [7:0]  a;
	logic [7:0]  b;
	logic        cin;

	logic [7:0]  add_b;
	logic        add_ci;
	logic [8:0]  add_r;
	logic        add_h;
	logic [7:0]  sub_b;
	logic        sub_ci;
	logic [8:0]  sub_r;
	logic        sub_h;

	logic [16:0] w_r;
	logic        w_h;
	logic [15:0] sp_ext;
	logic [15:0] sp_r;
	logic        sp_h;
	logic        sp_c;

	logic [7:0]  sh_r;
	logic        sh_c;
	logic [7:0]  bmask;

	assign a   = opa[7:0];
	assign b   = opb[7:0];
	assign cin = flags_in.c;

	// Shared 8-bit adder and subtractor; inc and dec reuse them with a constant one
	assign add_b  = (mode == MODE_INC) ? 8'h01 : b;
	assign add_ci = (mode == MODE_ADC) ? cin : 1'b0;
	assign add_r  = {1'b0, a} + {1'b0, add_b} + {8'h00, add_ci};
	assign add_h  = a[4] ^ add_b[4] ^ add_r[4];

	assign sub_b  = (mode == MODE_DEC) ? 8'h01 : b;
	assign sub_ci = (mode == MODE_SBC) ? cin : 1'b0;
	assign sub_r  = {1'b0, a} - {1'b0, sub_b} - {8'h00, sub_ci};
	assign sub_h  = a[4] ^ sub_b[4] ^ sub_r[4];

	// 16-bit pair add: half carry out of bit 11, carry out of bit 15
	assign w_r = {1'b0, opa} + {1'b0, opb};
	assign w_h = opa[12] ^ opb[12] ^ w_r[12];

	// SP plus signed byte: flags come from the low-byte carries
	assign sp_ext = {{8{b[7]}}, b};
	assign sp_r   = opa + sp_ext;
	assign sp_h   = opa[4] ^ sp_ext[4] ^ sp_r[4];
	assign sp_c   = opa[8] ^ sp_ext[8] ^ sp_r[8];

	assign bmask = 8'h01 << bit_index;

	// Rotate and shift network
	always_comb begin
		sh_r = a;
		sh_c = 1'b0;
		case (mode)
			MODE_RLCA, MODE_RLC: begin
				sh_r = {a[6:0], a[7]};
				sh_c = a[7];
			end
			MODE_RRCA, MODE_RRC: begin
				sh_r = {a[0], a[7:1]};
				sh_c = a[0];
			end
			MODE_RLA, MODE_RL: begin
				sh_r = {a[6:0], cin};
				sh_c = a[7];
			end
			MODE_RRA, MODE_RR: begin
				sh_r = {cin, a[7:1]};
				sh_c = a[0];
			end
			MODE_SLA: begin
				sh_r = {a[6:0], 1'b0};
				sh_c = a[7];
			end
			MODE_SRA: begin
				sh_r = {a[7], a[7:1]};
				sh_c = a[0];
			end
			MODE_SWAP: begin
				sh_r = {a[3:0], a[7:4]};
				sh_c = 1'b0;
			end
			MODE_SRL: begin
				sh_r = {1'b0, a[7:1]};
				sh_c = a[0];
			end
			default: begin
				sh_r = a;
				sh_c = 1'b0;
			end
		endcase
	end

	always_comb begin
		result    = {8'h00, a};
		flags_out = flags_in;
		case (mode)
			MODE_ADD, MODE_ADC: begin
				result    = {8'h00, add_r[7:0]};
				flags_out = '{z: (add_r[7:0] == 8'h00), n: 1'b0, h: add_h, c: add_r[8]};
			end
			MODE_SUB, MODE_SBC: begin
				result    = {8'h00, sub_r[7:0]};
				flags_out = '{z: (sub_r[7:0] == 8'h00), n: 1'b1, h: sub_h, c: sub_r[8]};
			end
			MODE_CP: begin
				flags_out = '{z: (sub_r[7:0] == 8'h00), n: 1'b1, h: sub_h, c: sub_r[8]};
			end
			MODE_AND: begin
				result    = {8'h00, a & b};
				flags_out = '{z: ((a & b) == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			MODE_XOR: begin
				result    = {8'h00, a ^ b};
				flags_out = '{z: ((a ^ b) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			MODE_OR: begin
				result    = {8'h00, a | b};
				flags_out = '{z: ((a | b) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			MODE_INC: begin
				result    = {8'h00, add_r[7:0]};
				flags_out = '{z: (add_r[7:0] == 8'h00), n: 1'b0, h: add_h, c: cin};
			end
			MODE_DEC: begin
				result    = {8'h00, sub_r[7:0]};
				flags_out = '{z: (sub_r[7:0] == 8'h00), n: 1'b1, h: sub_h, c: cin};
			end
			MODE_RLCA, MODE_RRCA, MODE_RLA, MODE_RRA: begin
				// accumulator forms always clear zero
				result    = {8'h00, sh_r};
				flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: sh_c};
			end
			MODE_RLC, MODE_RRC, MODE_RL, MODE_RR, MODE_SLA, MODE_SRA, MODE_SWAP,
			MODE_SRL: begin
				result    = {8'h00, sh_r};
				flags_out = '{z: (sh_r == 8'h00), n: 1'b0, h: 1'b0, c: sh_c};
			end
			MODE_BIT: begin
				flags_out = '{z: ~a[bit_index], n: 1'b0, h: 1'b1, c: cin};
			end
			MODE_RES: begin
				result = {8'h00, a & ~bmask};
			end
			MODE_SET: begin
				result = {8'h00, a | bmask};
			end
			MODE_CPL: begin
				result    = {8'h00, ~a};
				flags_out = '{z: flags_in.z, n: 1'b1, h: 1'b1, c: cin};
			end
			MODE_CCF: begin
				flags_out = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: ~cin};
			end
			MODE_SCF: begin
				flags_out = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: 1'b1};
			end
			MODE_ADD16: begin
				result    = w_r[15:0];
				flags_out = '{z: flags_in.z, n: 1'b0, h: w_h, c: w_r[16]};
			end
			MODE_ADDSP: begin
				result    = sp_r;
				flags_out = '{z: 1'b0, n: 1'b0, h: sp_h, c: sp_c};
			end
			MODE_INC16: begin
				result = opa + 16'h0001;
			end
			MODE_DEC16: begin
				result = opa - 16'h0001;
			end
			default: begin
				result    = {8'h00, a};
				flags_out = flags_in;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> verif/tb_cpu_alu_with_flags.sv
// Self-checking testbench for the 8-bit ALU with flags: queue-fed driver, predictor and checker.
`timescale 1ns / 1ps

module tb_cpu_alu_with_flags;
	import alu_flg_pkg::*;

	// One operation as sent to the block
	typedef struct {
		mode_t       mode;
		logic [15:0] a;
		logic [15:0] b;
		logic [2:0]  bi;
		flags_t      fin;
	} alu_op_t;

	// One result as returned by the block; packed so a whole beat compares at once
	typedef struct packed {
		logic [15:0] value;
		flags_t      flags;
	} alu_res_t;

	localparam int RANDOM_OPS   = 1600;
	localparam int QUIET_LIMIT  = 1000;
	localparam int TAIL_CYCLES  = 4;
	localparam int REPORT_LIMIT = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [4:0]  mode = '0;
	logic [15:0] operand_a = '0;
	logic [15:0] operand_b = '0;
	logic [2:0]  bit_index = '0;
	logic        in_zero = 1'b0;
	logic        in_sub = 1'b0;
	logic        in_half = 1'b0;
	logic        in_carry = 1'b0;
	logic        busy;
	logic        done;
	logic [15:0] result;
	logic        out_zero;
	logic        out_sub;
	logic        out_half;
	logic        out_carry;

	alu_op_t  pending_ops[$];
	alu_res_t alu_results_due[$];
	alu_op_t  op_on_port;
	alu_res_t got_res;
	alu_res_t want_res;
	int       total_ops = 0;
	int       ops_issued = 0;
	int       send_idle_pct = 0;
	int       mismatches = 0;
	int       quiet_cycles = 0;

	cpu_alu_with_flags dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.bit_index (bit_index),
		.in_zero   (in_zero),
		.in_sub    (in_sub),
		.in_half   (in_half),
		.in_carry  (in_carry),
		.done      (done),
		.result    (result),
		.out_zero  (out_zero),
		.out_sub   (out_sub),
		.out_half  (out_half),
		.out_carry (out_carry)
	);

	always #2 clk = ~clk;

	// Compute the result and flags that one operation must give.
	function automatic alu_res_t alu_predict(alu_op_t op);
		logic [7:0]  a;
		logic [7:0]  t;
		logic [7:0]  v;
		logic [8:0]  s;
		logic [16:0] w;
		logic [15:0] sx;
		logic [15:0] r;
		logic        k;
		logic        co;
		flags_t      f;
		a = op.a[7:0];
		f = op.fin;
		r = {8'h00, a};
		// inc and dec work as add and sub of one; only adc and sbc take the carry in
		t = (op.mode == MODE_INC || op.mode == MODE_DEC) ? 8'h01 : op.b[7:0];
		k = (op.mode == MODE_ADC || op.mode == MODE_SBC) ? op.fin.c : 1'b0;
		v = a;
		co = 1'b0;
		case (op.mode)
			MODE_ADD, MODE_ADC, MODE_INC: begin
				s = {1'b0, a} + {1'b0, t} + {8'h00, k};
				r = {8'h00, s[7:0]};
				f.z = (s[7:0] == 8'h00);
				f.n = 1'b0;
				f.h = a[4] ^ t[4] ^ s[4];
				if (op.mode != MODE_INC) f.c = s[8];
			end
			MODE_SUB, MODE_SBC, MODE_CP, MODE_DEC: begin
				s = {1'b0, a} - {1'b0, t} - {8'h00, k};
				// compare keeps the operand and only sets flags
				if (op.mode != MODE_CP) r = {8'h00, s[7:0]};
				f.z = (s[7:0] == 8'h00);
				f.n = 1'b1;
				f.h = a[4] ^ t[4] ^ s[4];
				if (op.mode != MODE_DEC) f.c = s[8];
			end
			MODE_AND, MODE_XOR, MODE_OR: begin
				case (op.mode)
					MODE_AND: v = a & t;
					MODE_XOR: v = a ^ t;
					default:  v = a | t;
				endcase
				r = {8'h00, v};
				f = '{z: (v == 8'h00), n: 1'b0, h: (op.mode == MODE_AND), c: 1'b0};
			end
			MODE_RLCA, MODE_RRCA, MODE_RLA, MODE_RRA, MODE_RLC, MODE_RRC, MODE_RL, MODE_RR,
			MODE_SLA, MODE_SRA, MODE_SWAP, MODE_SRL: begin
				case (op.mode)
					MODE_RLCA, MODE_RLC: begin v = {a[6:0], a[7]};     co = a[7]; end
					MODE_RRCA, MODE_RRC: begin v = {a[0], a[7:1]};     co = a[0]; end
					MODE_RLA, MODE_RL:   begin v = {a[6:0], op.fin.c}; co = a[7]; end
					MODE_RRA, MODE_RR:   begin v = {op.fin.c, a[7:1]}; co = a[0]; end
					MODE_SLA:            begin v = {a[6:0], 1'b0};     co = a[7]; end
					MODE_SRA:            begin v = {a[7], a[7:1]};     co = a[0]; end
					MODE_SWAP:           begin v = {a[3:0], a[7:4]};   co = 1'b0; end
					default:             begin v = {1'b0, a[7:1]};     co = a[0]; end
				endcase
				r = {8'h00, v};
				f = '{z: (v == 8'h00), n: 1'b0, h: 1'b0, c: co};
				// accumulator rotates always clear Z
				if (op.mode inside {MODE_RLCA, MODE_RRCA, MODE_RLA, MODE_RRA}) f.z = 1'b0;
			end
			MODE_BIT: begin
				f.z = ~a[op.bi];
				f.n = 1'b0;
				f.h = 1'b1;
			end
			MODE_RES: r = {8'h00, a & ~(8'h01 << op.bi)};
			MODE_SET: r = {8'h00, a | (8'h01 << op.bi)};
			MODE_CPL: begin
				r = {8'h00, ~a};
				f.n = 1'b1;
				f.h = 1'b1;
			end
			MODE_CCF: begin
				f.n = 1'b0;
				f.h = 1'b0;
				f.c = ~op.fin.c;
			end
			MODE_SCF: begin
				f.n = 1'b0;
				f.h = 1'b0;
				f.c = 1'b1;
			end
			MODE_ADD16: begin
				// Z passes through; H from bit 11, C from bit 15
				w = {1'b0, op.a} + {1'b0, op.b};
				r = w[15:0];
				f.n = 1'b0;
				f.h = op.a[12] ^ op.b[12] ^ w[12];
				f.c = w[16];
			end
			MODE_ADDSP: begin
				// sign-extend the offset; carries come from the low byte
				sx = {{8{op.b[7]}}, op.b[7:0]};
				r = op.a + sx;
				f.z = 1'b0;
				f.n = 1'b0;
				f.h = op.a[4] ^ sx[4] ^ r[4];
				f.c = op.a[8] ^ sx[8] ^ r[8];
			end
			MODE_INC16: r = op.a + 16'h0001;
			default:    r = op.a - 16'h0001;
		endcase
		return '{value: r, flags: f};
	endfunction

	// Favor the edges of each byte, keep full random words in the mix.
	function automatic logic [15:0] pick_word();
		case ($urandom_range(7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return {8'($urandom), 8'hFF};
			3:       return {8'($urandom), 8'h0F};
			4:       return {8'($urandom), 8'h80};
			default: return 16'($urandom);
		endcase
	endfunction

	// Stimulus and end of run
	initial begin
		alu_op_t op;
		// directed: every operation once, operands at the byte and word extremes
		for (int m = 0; m < 32; m++) begin
			op.mode = mode_t'(m);
			op.a    = (m % 3 == 0) ? 16'hFFFF : ((m % 3 == 1) ? 16'h0F80 : 16'h0001);
			op.b    = m[1] ? 16'h0001 : 16'hFF80;
			op.bi   = 3'(m);
			op.fin  = flags_t'(m[0] ? 4'hF : 4'h0);
			pending_ops.push_back(op);
		end
		// a few corner beats: compare equal, word wrap both ways, negative SP offset
		pending_ops.push_back('{MODE_CP, 16'h1242, 16'hFF42, 3'd0, flags_t'(4'h0)});
		pending_ops.push_back('{MODE_ADD16, 16'hFFFF, 16'h0001, 3'd7, flags_t'(4'h8)});
		pending_ops.push_back('{MODE_INC16, 16'hFFFF, 16'h0000, 3'd0, flags_t'(4'h5)});
		pending_ops.push_back('{MODE_DEC16, 16'h0000, 16'hFFFF, 3'd0, flags_t'(4'hA)});
		pending_ops.push_back('{MODE_ADDSP, 16'h0000, 16'h00FF, 3'd0, flags_t'(4'hF)});
		for (int i = 0; i < RANDOM_OPS; i++) begin
			op.mode = mode_t'($urandom_range(31));
			op.a    = pick_word();
			op.b    = pick_word();
			op.bi   = 3'($urandom_range(7));
			op.fin  = flags_t'($urandom_range(15));
			pending_ops.push_back(op);
		end
		total_ops = pending_ops.size();

		// hold reset low, then release it at a rising edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// drain: every beat sent, every result seen
		while (pending_ops.size() != 0 || start || alu_results_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (alu_results_due.size() != 0) mismatches += alu_results_due.size();

		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Driver: record the beat taken at this edge, then present the next one or idle.
	// Idle 36% in the first third, 67% in the second, never in the last.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				alu_results_due.push_back(alu_predict(op_on_port));
				ops_issued++;
			end
			send_idle_pct = (ops_issued < total_ops / 3) ? 36 :
				((ops_issued < 2 * total_ops / 3) ? 67 : 0);
			// a stalled beat stays on the ports untouched
			if (!start || !busy) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					op_on_port = pending_ops.pop_front();
					start     <= 1'b1;
					mode      <= op_on_port.mode;
					operand_a <= op_on_port.a;
					operand_b <= op_on_port.b;
					bit_index <= op_on_port.bi;
					in_zero   <= op_on_port.fin.z;
					in_sub    <= op_on_port.fin.n;
					in_half   <= op_on_port.fin.h;
					in_carry  <= op_on_port.fin.c;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each strobed result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			got_res = '{value: result, flags: '{out_zero, out_sub, out_half, out_carry}};
			if (alu_results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result beat: result=%h znhc=%b",
						got_res.value, got_res.flags);
			end else begin
				want_res = alu_results_due.pop_front();
				if (got_res !== want_res) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("mismatch: result exp %h got %h, znhc exp %b got %b",
							want_res.value, got_res.value, want_res.flags, got_res.flags);
				end
			end
		end
	end

	// Watchdog: drop the run if neither side moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule

>>> files.f
hw/rtl/alu_flg_pkg.sv
hw/rtl/alu_flg_core.sv
hw/rtl/cpu_alu_with_flags.sv
verif/tb_cpu_alu_with_flags.sv
